// ===== sv/nst_pkg.sv =====
package nst_pkg;

  localparam int CMD_W       = 2;
  localparam int ST_W        = 2;
  localparam int KEY_IN_W    = 64;
  localparam int TIME_W      = 48;
  localparam int IN_FIELDS_W = CMD_W + KEY_IN_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ST_W + TIME_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_USED    = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  // lookup result flags
  typedef struct packed {
    logic hit;
    logic free;
  } lk_res_t;

  // table update request
  typedef struct packed {
    logic set;
    logic clr;
  } lk_upd_t;

endpackage

// ===== sv/nst_ram.sv =====
module nst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/nst_lookup.sv =====
module nst_lookup #(
  parameter int ENTRIES = 16,
  parameter int KEY_W = 64,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [KEY_W-1:0]     key_i,
  output nst_pkg::lk_res_t     res_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  input  nst_pkg::lk_upd_t     upd_i,
  input  logic [IDX_W-1:0]     upd_idx_i,
  input  logic [KEY_W-1:0]     upd_key_i
);

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [KEY_W-1:0]   key_r [ENTRIES];
  logic [ENTRIES-1:0] match;

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      match[e] = valid_r[e] && (key_r[e] == key_i);
    end
  end

  // lowest index wins
  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (match[e]) begin
        hit_idx_o = IDX_W'(e);
      end
      if (!valid_r[e]) begin
        free_idx_o = IDX_W'(e);
      end
    end
    res_o.hit  = |match;
    res_o.free = ~&valid_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (upd_i.set) begin
      valid_nxt[upd_idx_i] = 1'b1;
    end else if (upd_i.clr) begin
      valid_nxt[upd_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_i.set) begin
      key_r[upd_idx_i] <= upd_key_i;
    end
  end

endmodule

// ===== sv/named_stopwatch_table.sv =====
// Table of ENTRIES named stopwatches. Each input word carries a command (start, check,
// restart, stop), a key of up to KEY_CHARS characters (cut at the first zero character)
// and the current microsecond time; each yields exactly one result word with a status
// and a 48-bit elapsed time (the start time on a successful start, zero on error).
// Keys and valid bits sit in flops and are compared in parallel; start times live in a
// single-port-read RAM. A command has two steps: the key compare plus RAM read, then
// the read-modify-write and result load, which waits while a prior result is untaken.
// One command is in flight at a time: no new word is accepted until it loads its result.
module named_stopwatch_table #(
  parameter int ENTRIES = 16,
  parameter int KEY_CHARS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cmd[1:0], key[65:2], now_us[113:66], zero pad
  input  logic [nst_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], elapsed_us[49:2], zero pad
  output logic [nst_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W = 8 * KEY_CHARS;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  logic [nst_pkg::CMD_W-1:0]    in_cmd;
  logic [nst_pkg::KEY_IN_W-1:0] in_key;
  logic [nst_pkg::TIME_W-1:0]   in_now;
  logic [nst_pkg::KEY_IN_W-1:0] key_norm;
  logic [KEY_W-1:0]             key_cmp;
  logic                         alive;

  logic [nst_pkg::CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]           key_r;
  logic [nst_pkg::TIME_W-1:0] now_r;
  nst_pkg::lk_res_t           lk_r;
  logic [IDX_W-1:0]           hit_idx_r;
  logic [IDX_W-1:0]           free_idx_r;

  nst_pkg::lk_res_t lk_res;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  nst_pkg::lk_upd_t upd;
  logic [IDX_W-1:0] upd_idx;

  logic                       in_accept;
  logic                       exec_go;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [nst_pkg::TIME_W-1:0] start_rd;

  logic [nst_pkg::ST_W-1:0]   status_nxt;
  logic [nst_pkg::TIME_W-1:0] elapsed_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [nst_pkg::ST_W-1:0]   out_status_r;
  logic [nst_pkg::TIME_W-1:0] out_elapsed_r;

  assign in_cmd = in_tdata[nst_pkg::CMD_W-1:0];
  assign in_key = in_tdata[nst_pkg::CMD_W +: nst_pkg::KEY_IN_W];
  assign in_now = in_tdata[nst_pkg::CMD_W + nst_pkg::KEY_IN_W +: nst_pkg::TIME_W];

  // name ends at first zero char or at KEY_CHARS
  always_comb begin
    alive = 1'b1;
    key_norm = '0;
    for (int i = 0; i < 8; i++) begin
      alive = alive && (in_key[8*i +: 8] != 8'h00) && (i < KEY_CHARS);
      key_norm[8*i +: 8] = alive ? in_key[8*i +: 8] : 8'h00;
    end
  end
  assign key_cmp = key_norm[KEY_W-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  nst_lookup #(
    .ENTRIES(ENTRIES),
    .KEY_W  (KEY_W)
  ) u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_i     (key_cmp),
    .res_o     (lk_res),
    .hit_idx_o (hit_idx),
    .free_idx_o(free_idx),
    .upd_i     (upd),
    .upd_idx_i (upd_idx),
    .upd_key_i (key_r)
  );

  always_comb begin
    upd.set = exec_go && (cmd_r == nst_pkg::CMD_START) && !lk_r.hit && lk_r.free;
    upd.clr = exec_go && (cmd_r == nst_pkg::CMD_STOP) && lk_r.hit;
    upd_idx = (cmd_r == nst_pkg::CMD_START) ? free_idx_r : hit_idx_r;
  end

  assign ram_we    = upd.set || (exec_go && (cmd_r == nst_pkg::CMD_RESTART) && lk_r.hit);
  assign ram_waddr = upd_idx;

  nst_ram #(
    .WIDTH(nst_pkg::TIME_W),
    .DEPTH(ENTRIES)
  ) u_start_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(now_r),
    .re   (in_accept),
    .raddr(hit_idx),
    .rdata(start_rd)
  );

  always_comb begin
    status_nxt  = nst_pkg::ST_OK;
    elapsed_nxt = '0;
    if (cmd_r == nst_pkg::CMD_START) begin
      if (lk_r.hit) begin
        status_nxt = nst_pkg::ST_USED;
      end else if (!lk_r.free) begin
        status_nxt = nst_pkg::ST_FULL;
      end else begin
        elapsed_nxt = now_r;
      end
    end else if (!lk_r.hit) begin
      status_nxt = nst_pkg::ST_MISSING;
    end else begin
      elapsed_nxt = now_r - start_rd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r      <= in_cmd;
      key_r      <= key_cmp;
      now_r      <= in_now;
      lk_r       <= lk_res;
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
    end
    if (exec_go) begin
      out_status_r  <= status_nxt;
      out_elapsed_r <= elapsed_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = nst_pkg::OUT_TDATA_W'({out_elapsed_r, out_status_r});

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_EXEC))
    else $error("accepted word did not enter execute");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && (status_nxt != nst_pkg::ST_OK)) |-> (elapsed_nxt == '0))
    else $error("nonzero elapsed on error");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_tvalid && (state_r == S_IDLE)))
    else $error("execute did not load result");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd.set && upd.clr) && (!(upd.set || upd.clr || ram_we) || exec_go))
    else $error("table update outside execute");

endmodule
